>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error(msg);

// Check that cond never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error(msg);

`endif

>>> rtl/ccd_pkg.sv
`timescale 1ns / 1ps

package ccd_pkg;

	localparam int POINTS = 17;
	localparam int M      = POINTS - 1;

	localparam int AW      = $clog2(POINTS);
	localparam int KW      = 6;
	localparam int VAL_W   = 24;
	localparam int W_W     = 33;
	localparam int PROD_W  = VAL_W + W_W;
	localparam int ACC_W   = 64;
	localparam int FRAC_SH = 30;
	localparam int QW      = ACC_W - FRAC_SH;
	localparam int COS_N   = 2 * M;
	localparam int RW      = $clog2(COS_N);
	localparam int CORDIC_STEPS = 30;

	localparam logic [AW-1:0]   M_T      = AW'(M);
	localparam logic [KW-1:0]   M_K      = KW'(M);
	localparam logic [RW:0]     COS_N_R  = (RW + 1)'(COS_N);
	localparam logic [QW-1:0]   DIV_SMALL = QW'(M);
	localparam logic [QW-1:0]   DIV_BIG   = QW'(2 * M);
	localparam logic [ACC_W-1:0] HALF_SMALL = ACC_W'(M) << (FRAC_SH - 1);
	localparam logic [ACC_W-1:0] HALF_BIG   = ACC_W'(M) << FRAC_SH;
	localparam logic [QW-1:0]   Q_MAX_POS = QW'(64'h7FFF_FFFF);
	localparam logic [QW-1:0]   Q_MAX_NEG = QW'(64'h8000_0000);

	localparam logic signed [W_W-1:0] ONE_W     = W_W'(64'sd1 << FRAC_SH);
	localparam logic signed [W_W-1:0] NEG_ONE_W = -ONE_W;

	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam longint PI_Q30      = 64'sd3373259426;

	typedef longint atan_tab_t [CORDIC_STEPS];
	localparam atan_tab_t ATAN_Q30 = '{
		64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
		64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
		64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
		64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
		64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F, 64'sh0000003F,
		64'sh0000001F, 64'sh0000000F, 64'sh00000008, 64'sh00000004, 64'sh00000002
	};

	typedef logic signed [31:0] cos_tab_t [COS_N];

	// cos(pi * r / M) in Q30, r in [0, 2M)
	function automatic logic signed [31:0] cos_q30(int r_in);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		int r;
		bit neg;
		r = r_in;
		neg = 1'b0;
		if (r > M)
			r = 2 * M - r;
		if (2 * r > M) begin
			r = M - r;
			neg = 1'b1;
		end
		x = CORDIC_GAIN;
		y = 0;
		z = (PI_Q30 * longint'(r) + longint'(M / 2)) / M;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_Q30[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_Q30[i];
			end
		end
		if (neg)
			x = -x;
		return x[31:0];
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		for (int i = 0; i < COS_N; i++)
			tab[i] = cos_q30(i);
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

	typedef struct packed {
		logic signed [ACC_W-1:0] acc_re;
		logic signed [ACC_W-1:0] acc_im;
		logic [KW-1:0]           k;
	} acc_beat_t;

endpackage

>>> rtl/ccd_sample_ram.sv
`timescale 1ns / 1ps

module ccd_sample_ram (
	input  logic                            clk,
	input  logic                            we,
	input  logic [ccd_pkg::AW-1:0]          waddr,
	input  logic [2*ccd_pkg::VAL_W-1:0]     wdata,
	input  logic [ccd_pkg::AW-1:0]          raddr,
	output logic [2*ccd_pkg::VAL_W-1:0]     rdata
);

	logic [2*ccd_pkg::VAL_W-1:0] mem [ccd_pkg::POINTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ccd_mac.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ccd_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic [ccd_pkg::AW-1:0]        ram_raddr,
	input  logic [2*ccd_pkg::VAL_W-1:0]   ram_rdata,
	output logic                          acc_valid,
	input  logic                          acc_ready,
	output ccd_pkg::acc_beat_t            acc_beat,
	output logic                          busy
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_WAIT  = 4'b1000
	} mac_state_t;

	mac_state_t state_q;
	logic [ccd_pkg::KW-1:0] k_q;
	logic [ccd_pkg::AW-1:0] t_q;
	logic                   part_q;
	logic [ccd_pkg::RW-1:0] r_q;
	logic [ccd_pkg::RW:0]   r_sum;
	logic [ccd_pkg::RW-1:0] r_next;

	logic                              vld_s1, part_s1, last_s1;
	logic signed [ccd_pkg::W_W-1:0]    w_s1;
	logic signed [ccd_pkg::W_W-1:0]    w_d;
	logic signed [ccd_pkg::VAL_W-1:0]  f_sel;
	logic signed [ccd_pkg::PROD_W-1:0] prod_d;
	logic                              vld_s2, part_s2, last_s2;
	logic signed [ccd_pkg::PROD_W-1:0] prod_s2;
	logic signed [ccd_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;
	logic                              issue;
	logic                              handoff;

	assign issue   = (state_q == ST_RUN);
	assign handoff = (state_q == ST_WAIT) && acc_ready;

	assign ram_raddr = ccd_pkg::M_T - t_q;

	always_comb begin
		w_d = {ccd_pkg::COS_TAB[r_q], 1'b0};
		if (t_q == '0)
			w_d = ccd_pkg::ONE_W;
		else if (t_q == ccd_pkg::M_T)
			w_d = k_q[0] ? ccd_pkg::NEG_ONE_W : ccd_pkg::ONE_W;
	end

	always_comb begin
		r_sum = {1'b0, r_q} + (ccd_pkg::RW + 1)'(k_q);
		if (r_sum >= ccd_pkg::COS_N_R)
			r_sum = r_sum - ccd_pkg::COS_N_R;
		r_next = r_sum[ccd_pkg::RW-1:0];
	end

	assign f_sel  = part_s1 ? ram_rdata[2*ccd_pkg::VAL_W-1:ccd_pkg::VAL_W]
	                        : ram_rdata[ccd_pkg::VAL_W-1:0];
	assign prod_d = f_sel * w_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			t_q     <= '0;
			part_q  <= 1'b0;
			r_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						k_q     <= '0;
						t_q     <= '0;
						part_q  <= 1'b0;
						r_q     <= '0;
					end
				end
				ST_RUN: begin
					part_q <= ~part_q;
					if (part_q) begin
						if (t_q == ccd_pkg::M_T) begin
							state_q <= ST_DRAIN;
						end else begin
							t_q <= t_q + 1'b1;
							r_q <= r_next;
						end
					end
				end
				ST_DRAIN: begin
					if (vld_s2 && last_s2)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (acc_ready) begin
						if (k_q == ccd_pkg::M_K) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RUN;
							k_q     <= k_q + 1'b1;
							t_q     <= '0;
							part_q  <= 1'b0;
							r_q     <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= issue && part_q && (t_q == ccd_pkg::M_T);
			vld_s2  <= vld_s1;
			last_s2 <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		part_s1 <= part_q;
		w_s1    <= w_d;
		part_s2 <= part_s1;
		prod_s2 <= prod_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (handoff || (state_q == ST_IDLE)) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (vld_s2) begin
			if (part_s2)
				acc_im_q <= acc_im_q + ccd_pkg::ACC_W'(prod_s2);
			else
				acc_re_q <= acc_re_q + ccd_pkg::ACC_W'(prod_s2);
		end
	end

	assign acc_valid       = (state_q == ST_WAIT);
	assign acc_beat.acc_re = acc_re_q;
	assign acc_beat.acc_im = acc_im_q;
	assign acc_beat.k      = k_q;
	assign busy            = (state_q != ST_IDLE);

	`ASSERT_NEVER(a_t_range, clk, arst_n, t_q > ccd_pkg::M_T, "tap counter out of range")
	`ASSERT_CLK(a_wait_quiet, clk, arst_n, (state_q == ST_WAIT) |-> (!vld_s1 && !vld_s2),
		"products in flight while sum is offered")

endmodule

>>> rtl/ccd_div.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ccd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc_valid,
	output logic               acc_ready,
	input  ccd_pkg::acc_beat_t acc_beat,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [71:0]        m_axis_tdata,
	output logic               m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_DONE = 3'b100
	} div_state_t;

	div_state_t state_q;
	logic [ccd_pkg::ACC_W-1:0] mag_re_q, mag_im_q;
	logic                      neg_re_q, neg_im_q;
	logic [ccd_pkg::KW-1:0]    k_q;
	logic                      big_q;
	logic [ccd_pkg::QW-1:0]    q_re_q, q_im_q;

	logic [ccd_pkg::ACC_W-1:0] half;
	logic [ccd_pkg::ACC_W-1:0] sum_re, sum_im;
	logic [ccd_pkg::QW-1:0]    quo_re, quo_im;
	logic                      out_load;

	logic                      tvalid_q;
	logic [31:0]               re_q, im_q;
	logic [ccd_pkg::KW-1:0]    idx_q;
	logic                      last_q;

	function automatic logic [31:0] sat32(logic [ccd_pkg::QW-1:0] q, logic neg);
		logic [31:0] res;
		if (neg) begin
			if (q > ccd_pkg::Q_MAX_NEG)
				res = 32'h8000_0000;
			else
				res = -q[31:0];
		end else begin
			if (q > ccd_pkg::Q_MAX_POS)
				res = 32'h7FFF_FFFF;
			else
				res = q[31:0];
		end
		return res;
	endfunction

	assign acc_ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_DONE) && (!tvalid_q || m_axis_tready);

	assign half   = big_q ? ccd_pkg::HALF_BIG : ccd_pkg::HALF_SMALL;
	assign sum_re = mag_re_q + half;
	assign sum_im = mag_im_q + half;
	assign quo_re = big_q ? sum_re[ccd_pkg::ACC_W-1:ccd_pkg::FRAC_SH] / ccd_pkg::DIV_BIG
	                      : sum_re[ccd_pkg::ACC_W-1:ccd_pkg::FRAC_SH] / ccd_pkg::DIV_SMALL;
	assign quo_im = big_q ? sum_im[ccd_pkg::ACC_W-1:ccd_pkg::FRAC_SH] / ccd_pkg::DIV_BIG
	                      : sum_im[ccd_pkg::ACC_W-1:ccd_pkg::FRAC_SH] / ccd_pkg::DIV_SMALL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_valid) begin
					neg_re_q <= acc_beat.acc_re[ccd_pkg::ACC_W-1];
					neg_im_q <= acc_beat.acc_im[ccd_pkg::ACC_W-1];
					mag_re_q <= acc_beat.acc_re[ccd_pkg::ACC_W-1] ? -acc_beat.acc_re
					                                               : acc_beat.acc_re;
					mag_im_q <= acc_beat.acc_im[ccd_pkg::ACC_W-1] ? -acc_beat.acc_im
					                                               : acc_beat.acc_im;
					k_q      <= acc_beat.k;
					big_q    <= (acc_beat.k == '0) || (acc_beat.k == ccd_pkg::M_K);
				end
			end
			ST_PREP: begin
				q_re_q <= quo_re;
				q_im_q <= quo_im;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tvalid_q <= 1'b0;
		else if (out_load)
			tvalid_q <= 1'b1;
		else if (m_axis_tready)
			tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			re_q   <= sat32(q_re_q, neg_re_q);
			im_q   <= sat32(q_im_q, neg_im_q);
			idx_q  <= k_q;
			last_q <= (k_q == ccd_pkg::M_K);
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = {2'b00, idx_q, im_q, re_q};
	assign m_axis_tlast  = last_q;

	`ASSERT_CLK(a_idx_range, clk, arst_n, tvalid_q |-> (idx_q <= ccd_pkg::M_K),
		"coefficient index out of range")
	`ASSERT_CLK(a_last_flag, clk, arst_n, tvalid_q |-> (last_q == (idx_q == ccd_pkg::M_K)),
		"last flag does not match index")
	`ASSERT_CLK(a_prep_done, clk, arst_n, (state_q == ST_PREP) |=> (state_q == ST_DONE),
		"scaler step sequence wrong")

endmodule

>>> rtl/chebyshev_coefficients_dct.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload
// s_axis   in   tdata[23:0] value_re, tdata[47:24] value_im
// m_axis   out  tdata[31:0] coef_re, [63:32] coef_im, [69:64] coef_index; tlast last_coef
//
// Samples load at one beat per cycle while the multiply-accumulate unit is idle.
// The beat that completes POINTS samples starts the transform; s_axis_tready stays low
// until the last sum has been handed to the scaler. Each coefficient uses the shared
// multiply-accumulate unit for two products per tap, then drains its pipeline
// (stages s1 and s2) and hands the sum over to the scaler.
// The rounding scaler overlaps the next sums; a stalled m_axis holds it.

module chebyshev_coefficients_dct (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // value_re, value_im
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // coef_re, coef_im, coef_index, pad
	output logic        m_axis_tlast    // last_coef
);

	logic [ccd_pkg::AW-1:0]      load_count_q;
	logic                        accept;
	logic                        start;
	logic                        mac_busy;
	logic [ccd_pkg::AW-1:0]      ram_raddr;
	logic [2*ccd_pkg::VAL_W-1:0] ram_rdata;
	logic                        acc_valid;
	logic                        acc_ready;
	ccd_pkg::acc_beat_t          acc_beat;

	assign s_axis_tready = !mac_busy;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign start         = accept && (load_count_q == ccd_pkg::M_T);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			load_count_q <= '0;
		else if (accept)
			load_count_q <= start ? '0 : load_count_q + 1'b1;
	end

	ccd_sample_ram u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (load_count_q),
		.wdata (s_axis_tdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ccd_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc_beat  (acc_beat),
		.busy      (mac_busy)
	);

	ccd_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc_valid     (acc_valid),
		.acc_ready     (acc_ready),
		.acc_beat      (acc_beat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
